// ===== src/gbts_pkg.sv =====
package gbts_pkg;

    localparam logic [7:0] NEWLINE = 8'd10;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_LEFT   = 3'd2,
        OP_RIGHT  = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MV_RD,
        S_MV_WR,
        S_RC_RUN,
        S_RD_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0]  read_char;
        logic [12:0] text_length;
        logic [12:0] cursor_col;
        logic [12:0] cursor_line;
        logic [12:0] cursor_pos;
        status_t     status;
    } result_t;

endpackage

// ===== src/gbts_mem.sv =====
module gbts_mem
    import gbts_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);

    logic [7:0] mem_arr [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_arr[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_arr[rd_addr];
        end
    end

endmodule

// ===== src/gbts_ctrl.sv =====
module gbts_ctrl
    import gbts_pkg::*;
#(
    parameter int CAPACITY = 4096,
    parameter int AW       = 12,
    parameter int PW       = 13
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    op,
    input  logic [7:0]    ch,
    input  logic [11:0]   read_pos,
    output logic          res_valid,
    input  logic          res_ready,
    output result_t       res,
    output logic          mem_rd_en,
    output logic [AW-1:0] mem_rd_addr,
    input  logic [7:0]    mem_rd_data,
    output logic          mem_wr_en,
    output logic [AW-1:0] mem_wr_addr,
    output logic [7:0]    mem_wr_data
);

    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    logic [7:0]    ch_reg, ch_next;
    logic [PW-1:0] gf_reg, gf_next;
    logic [PW-1:0] gpe_reg, gpe_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] line_reg, line_next;
    logic [PW-1:0] col_reg, col_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic          rvld_reg, rvld_next;
    logic          dir_reg, dir_next;
    status_t       status_reg, status_next;
    logic [7:0]    rchar_reg, rchar_next;
    logic [PW-1:0] len;

    function automatic logic [AW-1:0] phys_of(input logic [PW-1:0] p,
                                              input logic [PW-1:0] gf,
                                              input logic [PW-1:0] gpe);
        logic [PW-1:0] a;
        begin
            a = (p < gf) ? p : PW'(gpe + (p - gf));
            return a[AW-1:0];
        end
    endfunction

    assign len = PW'(CAPACITY) - (gpe_reg - gf_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gf_reg    <= '0;
            gpe_reg   <= PW'(CAPACITY);
            cur_reg   <= '0;
            line_reg  <= '0;
            col_reg   <= '0;
            idx_reg   <= '0;
            rvld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gf_reg    <= gf_next;
            gpe_reg   <= gpe_next;
            cur_reg   <= cur_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            idx_reg   <= idx_next;
            rvld_reg  <= rvld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        ch_reg     <= ch_next;
        dir_reg    <= dir_next;
        status_reg <= status_next;
        rchar_reg  <= rchar_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        ch_next     = ch_reg;
        gf_next     = gf_reg;
        gpe_next    = gpe_reg;
        cur_next    = cur_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        idx_next    = idx_reg;
        rvld_next   = rvld_reg;
        dir_next    = dir_reg;
        status_next = status_reg;
        rchar_next  = rchar_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = op_t'(op);
                    ch_next     = ch;
                    status_next = ST_DONE;
                    rchar_next  = '0;
                    state_next  = S_FINISH;
                    idx_next    = '0;
                    rvld_next   = 1'b0;
                    unique case (op_t'(op))
                        OP_INSERT:
                        begin
                            if (gf_reg == gpe_reg)
                                status_next = ST_FULL;
                            else
                                state_next = S_MV_RD;
                        end
                        OP_DELETE:
                        begin
                            if (cur_reg == '0)
                                status_next = ST_IGNORED;
                            else
                                state_next = S_MV_RD;
                        end
                        OP_LEFT:
                        begin
                            if (cur_reg == '0)
                                status_next = ST_IGNORED;
                            else
                            begin
                                cur_next   = cur_reg - 1'b1;
                                line_next  = '0;
                                col_next   = '0;
                                state_next = S_RC_RUN;
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (cur_reg >= len)
                                status_next = ST_IGNORED;
                            else
                            begin
                                cur_next   = cur_reg + 1'b1;
                                line_next  = '0;
                                col_next   = '0;
                                state_next = S_RC_RUN;
                            end
                        end
                        OP_READ:
                        begin
                            if (32'(read_pos) >= 32'(len))
                                status_next = ST_IGNORED;
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = phys_of(PW'(read_pos), gf_reg, gpe_reg);
                                state_next  = S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            status_next = ST_IGNORED;
                        end
                    endcase
                end
            end

            S_MV_RD:
            begin
                // One byte crosses the gap per read/write pair.
                if (cur_reg < gf_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(gf_reg - 1'b1);
                    dir_next    = 1'b0;
                    state_next  = S_MV_WR;
                end
                else if (cur_reg > gf_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(gpe_reg);
                    dir_next    = 1'b1;
                    state_next  = S_MV_WR;
                end
                else if (op_reg == OP_INSERT)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = AW'(gf_reg);
                    mem_wr_data = ch_reg;
                    gf_next     = gf_reg + 1'b1;
                    cur_next    = cur_reg + 1'b1;
                    if (ch_reg == NEWLINE)
                    begin
                        line_next = line_reg + 1'b1;
                        col_next  = '0;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    gf_next    = gf_reg - 1'b1;
                    cur_next   = cur_reg - 1'b1;
                    line_next  = '0;
                    col_next   = '0;
                    state_next = S_RC_RUN;
                end
            end

            S_MV_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data;
                if (!dir_reg)
                begin
                    mem_wr_addr = AW'(gpe_reg - 1'b1);
                    gf_next     = gf_reg - 1'b1;
                    gpe_next    = gpe_reg - 1'b1;
                end
                else
                begin
                    mem_wr_addr = AW'(gf_reg);
                    gf_next     = gf_reg + 1'b1;
                    gpe_next    = gpe_reg + 1'b1;
                end
                state_next = S_MV_RD;
            end

            S_RC_RUN:
            begin
                // Reads are issued one per cycle; the data of the previous
                // read is counted in the same cycle.
                if (rvld_reg)
                begin
                    if (mem_rd_data == NEWLINE)
                    begin
                        line_next = line_reg + 1'b1;
                        col_next  = '0;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                if (idx_reg < cur_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = phys_of(idx_reg, gf_reg, gpe_reg);
                    idx_next    = idx_reg + 1'b1;
                    rvld_next   = 1'b1;
                end
                else
                begin
                    rvld_next = 1'b0;
                    if (!rvld_reg)
                        state_next = S_FINISH;
                end
            end

            S_RD_WAIT:
            begin
                rchar_next = mem_rd_data;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status      = status_reg;
    assign res.cursor_pos  = 13'(cur_reg);
    assign res.cursor_line = 13'(line_reg);
    assign res.cursor_col  = 13'(col_reg);
    assign res.text_length = 13'(len);
    assign res.read_char   = rchar_reg;

endmodule

// ===== src/gap_buffer_text_store.sv =====
// Channel   Direction  Content
// s_*       in         command transaction: op, ch, read_pos
// m_*       out        result transaction: status, cursor, line, column, length, char
//
// One command at a time. Insert and delete first shift the gap one byte at a time
// (read, then write of the single memory). Delete and cursor moves then recount
// newlines at one byte per cycle.
// Reset clears cursor, gap and counts at once; the text memory is not cleared.
// A finished result waits in an output register while the next command starts.
module gap_buffer_text_store
    import gbts_pkg::*;
#(
    parameter int CAPACITY = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op[2:0], ch[10:3], read_pos[22:11], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // status, cursor_pos, cursor_line, cursor_col,
                                   // text_length, read_char, zero pad
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);

    logic          res_valid;
    logic          res_ready;
    result_t       res;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          out_vld_reg, out_vld_next;
    result_t       out_reg, out_next;

    gbts_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    gbts_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .PW       (PW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .op          (s_tdata[2:0]),
        .ch          (s_tdata[10:3]),
        .read_pos    (s_tdata[22:11]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_en   (rd_en),
        .mem_rd_addr (rd_addr),
        .mem_rd_data (rd_data),
        .mem_wr_en   (wr_en),
        .mem_wr_addr (wr_addr),
        .mem_wr_data (wr_data)
    );

    assign res_ready = !out_vld_reg || m_tready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        if (res_valid && res_ready)
        begin
            out_vld_next = 1'b1;
            out_next     = res;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_reg};

endmodule

// ===== tb/gap_buffer_text_store_tb.sv =====
module gap_buffer_text_store_tb;
    import gbts_pkg::*;

    localparam int CAP = 4096;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    // Text model: a flat array of the logical text, plus cursor and counts.
    logic [7:0]  text_model [0:CAP-1];
    int          text_len_now;
    int          cursor_now;
    int          line_now_m;
    int          col_now_m;

    result_t     expected_results [$];
    int          mismatch_count;
    int          sent_count;
    bit          stall_hold;
    bit          quiet_mode;

    gap_buffer_text_store #(.CAPACITY(CAP)) i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic void recount_lines();
        int ln;
        int cl;
        ln = 0;
        cl = 0;
        for (int i = 0; i < cursor_now; i++) begin
            if (text_model[i] == NEWLINE) begin
                ln++;
                cl = 0;
            end
            else begin
                cl++;
            end
        end
        line_now_m = ln;
        col_now_m = cl;
    endfunction

    function automatic result_t apply_command(logic [2:0] op, logic [7:0] ch,
                                              logic [11:0] rp);
        result_t r;
        r.status = ST_DONE;
        r.read_char = 8'd0;
        case (op)
            OP_INSERT:
                if (text_len_now == CAP) begin
                    r.status = ST_FULL;
                end
                else begin
                    for (int i = text_len_now; i > cursor_now; i--)
                        text_model[i] = text_model[i-1];
                    text_model[cursor_now] = ch;
                    text_len_now++;
                    cursor_now++;
                    if (ch == NEWLINE) begin
                        line_now_m++;
                        col_now_m = 0;
                    end
                    else begin
                        col_now_m++;
                    end
                end
            OP_DELETE:
                if (cursor_now == 0) begin
                    r.status = ST_IGNORED;
                end
                else begin
                    for (int i = cursor_now - 1; i < text_len_now - 1; i++)
                        text_model[i] = text_model[i+1];
                    text_len_now--;
                    cursor_now--;
                    recount_lines();
                end
            OP_LEFT:
                if (cursor_now == 0) begin
                    r.status = ST_IGNORED;
                end
                else begin
                    cursor_now--;
                    recount_lines();
                end
            OP_RIGHT:
                if (cursor_now >= text_len_now) begin
                    r.status = ST_IGNORED;
                end
                else begin
                    cursor_now++;
                    recount_lines();
                end
            OP_READ:
                if (int'(rp) >= text_len_now) r.status = ST_IGNORED;
                else r.read_char = text_model[rp];
            default:
                r.status = ST_IGNORED;
        endcase
        r.cursor_pos = 13'(cursor_now);
        r.cursor_line = 13'(line_now_m);
        r.cursor_col = 13'(col_now_m);
        r.text_length = 13'(text_len_now);
        return r;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // The valid line stays high between back-to-back commands; it drops
    // only before an idle gap or when the sender is done.
    task automatic send_command(logic [2:0] op, logic [7:0] ch, logic [11:0] rp);
        int gap;
        gap = quiet_mode ? 0 : random_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        expected_results.push_back(apply_command(op, ch, rp));
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, rp, ch, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_count++;
    endtask

    // Receiver: random ready, with a forced long hold-off while stall_hold is set.
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (stall_hold) begin
                m_tready <= 1'b0;
            end
            else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
                gap = random_gap();
                m_tready <= 1'b0;
                repeat (gap + 1) @(posedge clk);
                m_tready <= 1'b1;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        result_t got;
        result_t exp_r;
        if (rst_n && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[61:0]);
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction %h", m_tdata);
            end
            else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r || m_tdata[63:62] !== 2'd0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected st=%0d pos=%0d ln=%0d col=%0d len=%0d rd=%0h, got st=%0d pos=%0d ln=%0d col=%0d len=%0d rd=%0h",
                            exp_r.status, exp_r.cursor_pos, exp_r.cursor_line,
                            exp_r.cursor_col, exp_r.text_length, exp_r.read_char,
                            got.status, got.cursor_pos, got.cursor_line,
                            got.cursor_col, got.text_length, got.read_char);
                end
            end
        end
    end

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed_edges();
        send_command(OP_DELETE, 8'h00, 12'd0);
        send_command(OP_LEFT, 8'h00, 12'd0);
        send_command(OP_RIGHT, 8'h00, 12'd0);
        send_command(OP_READ, 8'h00, 12'd0);
        send_command(OP_INSERT, 8'hFF, 12'd0);
        send_command(OP_INSERT, NEWLINE, 12'd0);
        send_command(OP_INSERT, 8'h00, 12'd0);
        send_command(OP_INSERT, 8'hA5, 12'd0);
        send_command(OP_LEFT, 8'h00, 12'd0);
        send_command(OP_LEFT, 8'h00, 12'd0);
        send_command(OP_INSERT, 8'h5A, 12'd0);
        send_command(OP_READ, 8'h00, 12'd4);
        send_command(OP_READ, 8'h00, 12'd5);
        send_command(OP_READ, 8'h00, 12'hFFF);
        send_command(OP_RIGHT, 8'h00, 12'd0);
        send_command(OP_RIGHT, 8'h00, 12'd0);
        send_command(OP_RIGHT, 8'h00, 12'd0);
        send_command(OP_DELETE, 8'h00, 12'd0);
        send_command(3'd5, 8'hFF, 12'hFFF);
        send_command(3'd6, 8'h00, 12'd0);
        send_command(3'd7, 8'h00, 12'd0);
        send_command(OP_READ, 8'h00, 12'd1);
        wait_drained();
    endtask

    // The receiver holds off while the sender keeps offering commands.
    task automatic test_output_backpressure();
        stall_hold = 1'b1;
        fork
            begin
                for (int i = 0; i < 6; i++)
                    send_command(OP_INSERT, 8'($urandom_range(0, 255)), 12'd0);
            end
            begin
                repeat (300) @(posedge clk);
                stall_hold = 1'b0;
            end
        join
        wait_drained();
    endtask

    task automatic test_random_editing();
        logic [2:0] op;
        int pick;
        for (int i = 0; i < 140; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) op = OP_INSERT;
            else if (pick < 52) op = OP_DELETE;
            else if (pick < 67) op = OP_LEFT;
            else if (pick < 80) op = OP_RIGHT;
            else if (pick < 96) op = OP_READ;
            else op = 3'($urandom_range(5, 7));
            send_command(op,
                ($urandom_range(0, 3) == 0) ? NEWLINE : 8'($urandom_range(0, 255)),
                ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                    : 12'($urandom_range(0, text_len_now + 1)));
        end
        wait_drained();
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        rst_n = 1'b0;
        stall_hold = 1'b0;
        quiet_mode = 1'b0;
        mismatch_count = 0;
        sent_count = 0;
        text_len_now = 0;
        cursor_now = 0;
        line_now_m = 0;
        col_now_m = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_output_backpressure();
        test_random_editing();
        repeat (20000) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gbts_pkg.sv
src/gbts_mem.sv
src/gbts_ctrl.sv
src/gap_buffer_text_store.sv
tb/gap_buffer_text_store_tb.sv
